FILE: rtl/fnm_pkg.sv
package fnm_pkg;

  localparam int NAME_COUNT  = 19;
  localparam int NAME_LENGTH = 5;
  localparam int SYMBOL_W    = 8;
  localparam int POS_W       = 3;
  localparam int INDEX_W     = 5;

  typedef enum logic [1:0] {
    ST_PENDING  = 2'd0,
    ST_MATCH    = 2'd1,
    ST_NO_MATCH = 2'd2
  } status_t;

  typedef logic [SYMBOL_W-1:0] char_t;

  // unused slots hold zero and never compare equal
  localparam char_t NAME_ROM [NAME_COUNT][NAME_LENGTH] = '{
    '{"s", "q", "r", "t", 8'h00},
    '{"c", "b", "r", "t", 8'h00},
    '{"a", "b", "s", 8'h00, 8'h00},
    '{"r", "a", "d", 8'h00, 8'h00},
    '{"s", "i", "n", 8'h00, 8'h00},
    '{"c", "o", "s", 8'h00, 8'h00},
    '{"t", "a", "n", 8'h00, 8'h00},
    '{"a", "s", "i", "n", 8'h00},
    '{"a", "c", "o", "s", 8'h00},
    '{"a", "t", "a", "n", 8'h00},
    '{"c", "s", "c", 8'h00, 8'h00},
    '{"s", "e", "c", 8'h00, 8'h00},
    '{"c", "o", "t", 8'h00, 8'h00},
    '{"f", "l", "o", "o", "r"},
    '{"t", "r", "u", "n", "c"},
    '{"c", "e", "i", "l", 8'h00},
    '{"r", "o", "u", "n", "d"},
    '{"l", "o", "g", "2", 8'h00},
    '{"l", "o", "g", "1", "0"}
  };

  // position of the final character of each name
  localparam logic [POS_W-1:0] LAST_POS [NAME_COUNT] = '{
    3'd3, 3'd3, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd3, 3'd3, 3'd3,
    3'd2, 3'd2, 3'd2, 3'd4, 3'd4, 3'd3, 3'd4, 3'd3, 3'd4
  };

endpackage

FILE: rtl/function_name_matcher.sv
// function name matcher
// s_tdata carries one character per transfer; each transfer yields exactly one
// result on the master side. m_tuser carries the status (pending, name matched,
// no name matches) and m_tdata the table index of the matched name, zero
// otherwise. A match or a mismatch restarts matching with every name live at
// the first character, so the next character begins a new name.
// Structure: an input register, a combinational parallel compare of the
// character against all table entries at the current position, and a result
// register, which drives m_tvalid. Throughput is one character per cycle
// while m_tready is high; the candidate mask and position update in the same
// cycle as the compare, so consecutive characters follow without a gap.
// When m_tready is low the result register holds and the input register
// still takes one more character; s_tready drops only when both are full.
// Reset clears both valid flags, marks every name live and sets the position
// to zero.
module function_name_matcher
  import fnm_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] symbol
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [4:0] name_index, [7:5] zero
  output logic [1:0] m_tuser    // [1:0] status
);

  logic                  in_valid;
  char_t                 in_symbol;
  logic [NAME_COUNT-1:0] live_mask;
  logic [NAME_COUNT-1:0] live_mask_next;
  logic [POS_W-1:0]      char_position;
  logic [POS_W-1:0]      char_position_next;
  status_t               out_status;
  status_t               status_next;
  logic [INDEX_W-1:0]    out_index;
  logic [INDEX_W-1:0]    index_next;

  logic                  out_free;
  logic                  advance;
  logic                  pos_ok;
  logic [POS_W-1:0]      pos_idx;
  logic [NAME_COUNT-1:0] hit;
  logic [NAME_COUNT-1:0] finish;
  logic [NAME_COUNT-1:0] cont_mask;

  assign out_free = !m_tvalid || m_tready;
  assign advance  = in_valid && out_free;
  assign s_tready = !in_valid || out_free;

  assign pos_ok  = char_position < POS_W'(NAME_LENGTH);
  assign pos_idx = pos_ok ? char_position : '0;

  always_comb begin
    for (int i = 0; i < NAME_COUNT; i++) begin
      hit[i] = live_mask[i] && (NAME_ROM[i][pos_idx] != '0) &&
               (NAME_ROM[i][pos_idx] == in_symbol);
      finish[i]    = hit[i] && (pos_idx == LAST_POS[i]);
      cont_mask[i] = hit[i] && (pos_idx != LAST_POS[i]);
    end
  end

  always_comb begin
    index_next = '0;
    // scan downward so the lowest finishing index wins
    for (int i = NAME_COUNT - 1; i >= 0; i--) begin
      if (finish[i]) begin
        index_next = INDEX_W'(i);
      end
    end
  end

  always_comb begin
    live_mask_next     = '1;
    char_position_next = '0;
    if (!pos_ok) begin
      status_next = ST_NO_MATCH;
    end else if (|finish) begin
      status_next = ST_MATCH;
    end else if (cont_mask == '0) begin
      status_next = ST_NO_MATCH;
    end else begin
      status_next        = ST_PENDING;
      live_mask_next     = cont_mask;
      char_position_next = char_position + POS_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid      <= 1'b0;
      m_tvalid      <= 1'b0;
      live_mask     <= '1;
      char_position <= '0;
    end else begin
      if (s_tready) begin
        in_valid <= s_tvalid;
      end
      if (out_free) begin
        m_tvalid <= in_valid;
      end
      if (advance) begin
        live_mask     <= live_mask_next;
        char_position <= char_position_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_symbol <= s_tdata;
    end
    if (advance) begin
      out_status <= status_next;
      out_index  <= (status_next == ST_MATCH) ? index_next : '0;
    end
  end

  assign m_tdata = {{(8 - INDEX_W){1'b0}}, out_index};
  assign m_tuser = out_status;

  a_live_nonzero: assert property (@(posedge clk) disable iff (rst)
    live_mask != '0)
    else $error("candidate mask empty");

  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    char_position < POS_W'(NAME_LENGTH))
    else $error("character position past longest name");

  a_restart: assert property (@(posedge clk) disable iff (rst)
    advance && status_next != ST_PENDING |=>
      live_mask == '1 && char_position == '0)
    else $error("matcher did not restart after a decision");

  a_index: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (out_status == ST_MATCH && out_index < INDEX_W'(NAME_COUNT)) ||
                 (out_status != ST_MATCH && out_index == '0))
    else $error("name index inconsistent with status");

endmodule
